// File: src/stbs_pkg.sv
package stbs_pkg;

    localparam int CMD_W   = 1;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
        logic [CNT_W-1:0] probe_count;
    } t_result;

endpackage

// File: src/stbs_in_if.sv
interface stbs_in_if;
    logic                               valid;
    logic                               ready;
    logic [stbs_pkg::CMD_W-1:0]         command;
    logic [stbs_pkg::IDX_W-1:0]         entry_index;
    logic signed [stbs_pkg::VAL_W-1:0]  item_value;

    modport source (output valid, output command, output entry_index, output item_value,
                    input ready);
    modport sink   (input valid, input command, input entry_index, input item_value,
                    output ready);
endinterface

// File: src/stbs_out_if.sv
interface stbs_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [stbs_pkg::IDX_W-1:0]  match_index;
    logic [stbs_pkg::CNT_W-1:0]  probe_count;

    modport source (output valid, output found, output match_index, output probe_count,
                    input ready);
    modport sink   (input valid, input found, input match_index, input probe_count,
                    output ready);
endinterface

// File: src/stbs_cfg_if.sv
interface stbs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [stbs_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/sorted_table_binary_search_unit.sv
// Sorted table with binary search lookup.
// i_in carries beats of {command, entry_index, item_value}. A load beat writes
// item_value into the table at entry_index (ignored beyond the table depth)
// and yields nothing. A search beat halves over the first entries_in_use
// entries and yields one beat on o_res: found, match_index, probe_count.
// i_cfg writes entries_in_use (saturates at TABLE_DEPTH); write it while idle.
// A load is written on its accept edge and leaves i_in.ready high. A search
// holds i_in.ready low through S_START, S_PROBE and S_DONE, with at most
// floor(log2(entries_in_use)) + 1 probes: it reads the table RAM's single
// read port once per cycle, one probe per read. The result is registered on
// o_res; a new beat is accepted while it waits. If o_res stalls with a result
// still pending, the next search finishes its probes and holds until the
// output register frees up. Reset clears the control state and entries_in_use;
// table contents are undefined until loaded and no clearing pass is run.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stbs_in_if.sink     i_in,
    stbs_out_if.source  o_res,
    stbs_cfg_if.sink    i_cfg
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [VAL_W-1:0] wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic signed [VAL_W-1:0] rdata;

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    stbs_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// File: src/stbs_ram.sv
module stbs_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_wdata,
    input  logic                              i_re,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [stbs_pkg::VAL_W-1:0] o_rdata
);
    import stbs_pkg::*;

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/stbs_ctrl.sv
module stbs_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    stbs_in_if.sink                           i_in,
    stbs_out_if.source                        o_res,
    stbs_cfg_if.sink                          i_cfg,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic signed [stbs_pkg::VAL_W-1:0] o_wdata,
    output logic                              o_re,
    output logic [AW-1:0]                     o_raddr,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_rdata
);
    import stbs_pkg::*;

    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_entries;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [NW-1:0]           r_lo, n_lo;
    logic [NW-1:0]           r_hip1, n_hip1;
    logic [NW-1:0]           r_mid, n_mid;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    t_result                 r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    logic                    in_take;
    logic                    out_free;
    logic [CW-1:0]           sat_n;
    logic [NW-1:0]           lo_a, hip1_a;
    logic [NW:0]             mid_sum;
    logic [NW-1:0]           mid_a;
    logic [CNT_W-1:0]        cnt_p1;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_take     = i_in.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;
    assign cnt_p1      = r_cnt + CNT_W'(1);

    assign sat_n = (CW'(r_entries) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_entries);

    // table write for load beats, taken on the accept edge
    assign o_we    = in_take && (i_in.command == CMD_LOAD)
                     && (32'(i_in.entry_index) < 32'(TABLE_DEPTH));
    assign o_waddr = AW'(i_in.entry_index);
    assign o_wdata = i_in.item_value;

    // bounds for the next probe: current ones in S_START, updated ones in S_PROBE
    always_comb begin
        lo_a   = r_lo;
        hip1_a = r_hip1;
        if (r_state == S_PROBE) begin
            if (i_rdata < r_key) begin
                lo_a = r_mid + NW'(1);
            end else begin
                hip1_a = r_mid;
            end
        end
    end

    assign mid_sum = {1'b0, lo_a} + {1'b0, hip1_a} - (NW+1)'(1);
    assign mid_a   = mid_sum[NW:1];
    assign o_raddr = AW'(mid_a);

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hip1      = r_hip1;
        n_mid       = r_mid;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_re        = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take && (i_in.command == CMD_SEARCH)) begin
                    n_key   = i_in.item_value;
                    n_lo    = '0;
                    n_hip1  = NW'(sat_n);
                    n_cnt   = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (lo_a < hip1_a) begin
                    o_re    = 1'b1;
                    n_mid   = mid_a;
                    n_state = S_PROBE;
                end else begin
                    n_res   = '{found: 1'b0, match_index: '0, probe_count: cnt_p1};
                    n_state = S_DONE;
                end
            end
            S_PROBE: begin
                n_cnt = cnt_p1;
                if (i_rdata == r_key) begin
                    n_res   = '{found: 1'b1, match_index: IDX_W'(r_mid), probe_count: cnt_p1};
                    n_state = S_DONE;
                end else if (lo_a < hip1_a) begin
                    o_re   = 1'b1;
                    n_lo   = lo_a;
                    n_hip1 = hip1_a;
                    n_mid  = mid_a;
                end else begin
                    n_res   = '{found: 1'b0, match_index: '0,
                                probe_count: cnt_p1 + CNT_W'(1)};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_entries <= i_cfg.data;
            end
        end
        r_key  <= n_key;
        r_lo   <= n_lo;
        r_hip1 <= n_hip1;
        r_mid  <= n_mid;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out.found;
    assign o_res.match_index = r_out.match_index;
    assign o_res.probe_count = r_out.probe_count;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int SETTLE      = 24;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 16;
    localparam int DENSE_MAX   = 64;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_NEG_ONE = -32'sd1;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] item_value;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stbs_in_if  in_if();
    stbs_out_if res_if();
    stbs_cfg_if cfg_if();

    sorted_table_binary_search_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_request                request_q [$];
    t_result                 lookup_q [$];
    t_request                next_req;
    t_result                 want;

    // predictor state
    logic signed [VAL_W-1:0] mirror_words [TABLE_DEPTH];
    logic [CFG_W-1:0]        mirror_span = '0;

    // generator's view of table contents
    logic signed [VAL_W-1:0] plan_vals [TABLE_DEPTH];
    bit                      plan_set [TABLE_DEPTH];

    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      mismatches = 0;
    int                      quiet_cycles = 0;
    int unsigned             span_plan [PHASES];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result bisect(logic signed [VAL_W-1:0] key);
        int               lo;
        int               hi;
        int               mid;
        logic [CNT_W-1:0] probes;
        t_result          r;
        r      = '0;
        probes = '0;
        lo     = 0;
        hi     = ((mirror_span > TABLE_DEPTH) ? TABLE_DEPTH : int'(mirror_span)) - 1;
        while (lo <= hi && !r.found) begin
            mid    = (lo + hi) / 2;
            probes = probes + 1'b1;
            if (mirror_words[mid] == key) begin
                r.found       = 1'b1;
                r.match_index = mid[IDX_W-1:0];
            end else if (mirror_words[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        if (!r.found) begin
            probes = probes + 1'b1;
        end
        r.probe_count = probes;
        return r;
    endfunction

    // ascending values used for sparsely loaded large tables
    function automatic logic signed [VAL_W-1:0] ramp_val(int idx);
        return VAL_W'(idx * 8 - 4096);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (in_if.command == CMD_LOAD) begin
                    mirror_words[in_if.entry_index] = in_if.item_value;
                end else begin
                    lookup_q.push_back(bisect(in_if.item_value));
                end
            end
            if (!in_if.valid || in_if.ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_q.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.command     <= next_req.command;
                    in_if.entry_index <= next_req.entry_index;
                    in_if.item_value  <= next_req.item_value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (lookup_q.size() == 0) begin
                    $error("unexpected result beat: found %0b match_index %0d probe_count %0d",
                           res_if.found, res_if.match_index, res_if.probe_count);
                    mismatches++;
                end else begin
                    want = lookup_q.pop_front();
                    if (res_if.found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, res_if.found);
                        mismatches++;
                    end
                    if (res_if.match_index !== want.match_index) begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, res_if.match_index);
                        mismatches++;
                    end
                    if (res_if.probe_count !== want.probe_count) begin
                        $error("probe_count: expected %0d, got %0d",
                               want.probe_count, res_if.probe_count);
                        mismatches++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic push_load(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
        request_q.push_back('{command: CMD_LOAD, entry_index: idx, item_value: val});
        plan_vals[idx] = val;
        plan_set[idx]  = 1'b1;
    endtask

    task automatic push_search(logic signed [VAL_W-1:0] key);
        request_q.push_back('{command: CMD_SEARCH, entry_index: IDX_W'($urandom),
                              item_value: key});
    endtask

    // load every entry that a search for key will probe, ahead of the search
    task automatic cover_path(logic signed [VAL_W-1:0] key, int used);
        int lo;
        int hi;
        int mid;
        bit hit;
        lo  = 0;
        hi  = used - 1;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (!plan_set[mid] || plan_vals[mid] != ramp_val(mid)) begin
                push_load(IDX_W'(mid), ramp_val(mid));
            end
            if (plan_vals[mid] == key) begin
                hit = 1'b1;
            end else if (plan_vals[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
    endtask

    // wait at the falling edge so that the driver's updates have settled
    task automatic wait_drained(int settle);
        do @(negedge i_clk);
        while (request_q.size() != 0 || in_if.valid || lookup_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_span(logic [CFG_W-1:0] span);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= span;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        mirror_span = span;
        cfg_if.valid <= 1'b0;
    endtask

    // ascending contents for entries 0..count-1, with occasional repeats
    task automatic fill_sorted(int count);
        longint cur;
        longint stride_max;
        if ($urandom_range(99) < 30) begin
            stride_max = 3;
            cur = longint'($signed($urandom));
            if (cur > 64'sd2147483647 - 4 * count) begin
                cur = cur - 4 * count;
            end
        end else begin
            stride_max = (64'sd4294967296 / count) - 1;
            cur = -64'sd2147483648 + longint'($urandom_range(stride_max[31:0]));
        end
        for (int i = 0; i < count; i++) begin
            push_load(i[IDX_W-1:0], cur[VAL_W-1:0]);
            if ($urandom_range(9) != 0) begin
                cur = cur + longint'($urandom_range(stride_max[31:0]));
            end
        end
    endtask

    task automatic run_phase(int unsigned span, int mode);
        int                      used;
        int                      pick;
        logic signed [VAL_W-1:0] key;
        used = (span > TABLE_DEPTH) ? TABLE_DEPTH : int'(span);
        wait_drained(SETTLE);
        send_idle_pct  = (mode == 1) ? 81 : (mode == 3) ? 38 : 0;
        recv_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 38 : 0;
        write_span(span[CFG_W-1:0]);
        if (used > 0 && used <= DENSE_MAX) begin
            fill_sorted(used);
        end
        for (int b = 0; b < PHASE_BEATS; b++) begin
            if (b == PHASE_BEATS / 2) begin
                wait_drained(0);
            end
            if ($urandom_range(99) < 15) begin
                push_load(IDX_W'($urandom_range(TABLE_DEPTH - 1)), $signed($urandom));
            end else begin
                key = $signed($urandom);
                if (used > DENSE_MAX) begin
                    pick = int'($urandom_range(used - 1));
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: key = ramp_val(pick);
                        6:                key = ramp_val(pick) + 1;
                        7:                key = ramp_val(pick) - 1;
                        8:                key = VAL_NEG_ONE;
                        default:          key = $signed($urandom);
                    endcase
                    cover_path(key, used);
                end else if (used > 0) begin
                    pick = int'($urandom_range(used - 1));
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: key = plan_vals[pick];
                        6:                key = plan_vals[pick] + 1;
                        7:                key = plan_vals[pick] - 1;
                        8:                key = VAL_NEG_ONE;
                        default:          key = $signed($urandom);
                    endcase
                end
                push_search(key);
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.command      = CMD_LOAD;
        in_if.entry_index  = '0;
        in_if.item_value   = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        span_plan = '{5, 1024, 17, 0, 2047, 1, 33, 2, 9, 3};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table straight out of reset
        push_search('0);
        push_search(VAL_MIN);

        push_load(10'd0, VAL_MIN);
        push_load(10'd1, -32'sd1000);
        push_load(10'd2, VAL_NEG_ONE);
        push_load(10'd3, 32'sd0);
        push_load(10'd4, 32'sd1);
        push_load(10'd5, 32'sd5);
        push_load(10'd6, 32'sd5);
        push_load(10'd7, VAL_MAX);
        push_load(10'd1023, 32'sd0);
        wait_drained(SETTLE);
        write_span(11'd8);
        push_search(VAL_MIN);
        push_search(VAL_MAX);
        push_search(VAL_NEG_ONE);
        push_search(32'sd5);
        push_search(32'sd3);
        push_search(VAL_MAX - 1);
        push_search(VAL_MIN + 1);
        wait_drained(SETTLE);
        write_span(11'd1);
        push_search(VAL_MIN);
        push_search(VAL_MAX);

        for (int p = 0; p < PHASES; p++) begin
            run_phase(span_plan[p], p % 4);
        end

        wait_drained(SETTLE);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
